@@ src/countdown_timer_with_colon_blink_unit_defines.svh @@
// Assertion macros for the countdown timer with colon blink.
// Included by the RTL files that carry assertions; needs nothing else.
// Under SYNTHESIS the macros expand to nothing.
`ifndef COUNTDOWN_TIMER_WITH_COLON_BLINK_UNIT_DEFINES_SVH
`define COUNTDOWN_TIMER_WITH_COLON_BLINK_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CTWCB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
// Next-cycle implication, disabled during reset.
`define CTWCB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define CTWCB_ASSERT_IMP(label, clk, rst, ante, cons)
`define CTWCB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/ctwcb_pkg.sv @@
// Shared types and constants of the countdown timer with colon blink.
// Used by ctwcb_csr, ctwcb_core and the top level; depends on nothing.
package ctwcb_pkg;

   // Action codes of an input transaction. Code 3 does nothing.
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_ADJUST = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STEP        = 2'd0;
   localparam logic [1:0] CSR_MAX         = 2'd1;
   localparam logic [1:0] CSR_START_DELAY = 2'd2;
   localparam logic [1:0] CSR_BLINK_DELAY = 2'd3;

   // Configuration reset values.
   localparam logic [11:0] STEP_RESET        = 12'd60;
   localparam logic [15:0] MAX_RESET         = 16'd5999;
   localparam logic [15:0] START_DELAY_RESET = 16'd1000;
   localparam logic [15:0] BLINK_DELAY_RESET = 16'd1000;

   // Timing constants.
   localparam logic [31:0] SECOND_MS        = 32'd1000;
   localparam logic [8:0]  HALF_PERIOD_LAST = 9'd499;

   typedef struct packed {
      logic [11:0] step_seconds;
      logic [15:0] max_seconds;
      logic [15:0] start_delay_ms;
      logic [15:0] blink_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic [15:0] seconds_left;
      logic        expired;
      logic        colon_on;
   } result_type;

endpackage

@@ src/countdown_timer_with_colon_blink_unit.sv @@
// Countdown timer with a blinking display colon, driven by transactions.
// Depends on ctwcb_pkg, ctwcb_csr, ctwcb_core and the assertion macro header.
//
// Each input transaction is a millisecond tick, an adjust of the count by
// direction times step_seconds (saturated to 0..max_seconds), or a clear of
// the count, and each produces exactly one result transaction carrying the
// seconds left, an expired flag and the colon state. A transaction is taken
// in a cycle in which req_ready is high: the timer state is updated at the
// accepting edge and the result is loaded into an output register at the
// same edge, so the sustained rate is one transaction per clock while
// rsp_ready stays high. The output register is the only buffering; a new
// transaction is taken whenever it is empty or is being drained in the same
// cycle. The colon is lit before the blink start and then alternates every
// 500 ticks; all time comparisons use signed 32-bit differences and so hold
// across wraparound of the millisecond clock. Configuration writes on the
// csr_ channel are always accepted and take effect for the next transaction;
// they are meant to be issued only while no transaction is outstanding.
`include "countdown_timer_with_colon_blink_unit_defines.svh"
module countdown_timer_with_colon_blink_unit (
   input  logic              clock,
   input  logic              reset,
   // Input transactions.
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic signed [3:0] req_direction,
   // Result transactions.
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_seconds_left,
   output logic              rsp_expired,
   output logic              rsp_colon_on,
   // Configuration writes.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import ctwcb_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;

   // The output register can take a new result when it is empty or when its
   // current result leaves in this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   ctwcb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   ctwcb_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_take),
      .action    (req_action),
      .direction (req_direction),
      .cfg       (cfg),
      .result    (result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seconds_left = rsp_ff.seconds_left;
   assign rsp_expired      = rsp_ff.expired;
   assign rsp_colon_on     = rsp_ff.colon_on;

   // A shown result flags expiry exactly when its count is zero.
   `CTWCB_ASSERT_IMP(a_expired_match, clock, reset, rsp_valid_ff, rsp_expired == (rsp_seconds_left == 16'd0))
   // Every accepted transaction leaves a result in the output register.
   `CTWCB_ASSERT_NXT(a_take_gives_rsp, clock, reset, req_take, rsp_valid_ff)
   // An adjust never leaves the count above the limit.
   `CTWCB_ASSERT_NXT(a_adjust_limit, clock, reset, req_take && (req_action == ACT_ADJUST), rsp_seconds_left <= $past(cfg.max_seconds))
   // A clear always reports an expired timer.
   `CTWCB_ASSERT_NXT(a_clear_expires, clock, reset, req_take && (req_action == ACT_CLEAR), rsp_expired && rsp_colon_on == $past(result.colon_on))

endmodule

@@ src/ctwcb_csr.sv @@
// Configuration registers of the countdown timer with colon blink.
// Depends on ctwcb_pkg for register indexes, reset values and cfg_type.
module ctwcb_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [1:0]           wr_index,
   input  logic [15:0]          wr_data,
   output ctwcb_pkg::cfg_type   cfg
);
   import ctwcb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_STEP:        cfg_in.step_seconds   = wr_data[11:0];
            CSR_MAX:         cfg_in.max_seconds    = wr_data;
            CSR_START_DELAY: cfg_in.start_delay_ms = wr_data;
            CSR_BLINK_DELAY: cfg_in.blink_delay_ms = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_seconds   <= STEP_RESET;
         cfg_ff.max_seconds    <= MAX_RESET;
         cfg_ff.start_delay_ms <= START_DELAY_RESET;
         cfg_ff.blink_delay_ms <= BLINK_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/ctwcb_core.sv @@
// Timer state and per-transaction update of the countdown timer.
// Depends on ctwcb_pkg for action codes, timing constants and struct types.
module ctwcb_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [1:0]            action,
   input  logic signed [3:0]     direction,
   input  ctwcb_pkg::cfg_type    cfg,
   output ctwcb_pkg::result_type result
);
   import ctwcb_pkg::*;

   // The blink phase is kept as the running difference clock - origin plus a
   // position within the current 500 ms half period and its parity, so no
   // division is needed to find the colon state.
   logic [31:0] clock_ff, clock_in;
   logic [31:0] next_dec_ff, next_dec_in;
   logic [31:0] blink_diff_ff, blink_diff_in;
   logic [8:0]  half_pos_ff, half_pos_in;
   logic        half_odd_ff, half_odd_in;
   logic [15:0] count_ff, count_in;

   logic [31:0]        clock_plus;
   logic [31:0]        dec_gap;
   logic               dec_hit;
   logic [31:0]        diff_plus;
   logic signed [16:0] delta;
   logic signed [17:0] sum;

   always_comb begin
      clock_plus  = clock_ff + 32'd1;
      dec_gap     = clock_plus - next_dec_ff;
      dec_hit     = (count_ff != 16'd0) && !dec_gap[31];
      diff_plus   = blink_diff_ff + 32'd1;
      delta       = direction * $signed({1'b0, cfg.step_seconds});
      sum         = $signed({2'b00, count_ff}) + $signed({delta[16], delta});

      clock_in      = clock_ff;
      next_dec_in   = next_dec_ff;
      blink_diff_in = blink_diff_ff;
      half_pos_in   = half_pos_ff;
      half_odd_in   = half_odd_ff;
      count_in      = count_ff;

      if (step_en) begin
         unique case (action)
            ACT_TICK: begin
               clock_in = clock_plus;
               if (dec_hit) begin
                  next_dec_in   = next_dec_ff + SECOND_MS;
                  count_in      = count_ff - 16'd1;
                  blink_diff_in = 32'd0;
                  half_pos_in   = 9'd0;
                  half_odd_in   = 1'b0;
               end else begin
                  blink_diff_in = diff_plus;
                  if (diff_plus == 32'd0) begin
                     half_pos_in = 9'd0;
                     half_odd_in = 1'b0;
                  end else if (!blink_diff_ff[31]) begin
                     if (half_pos_ff == HALF_PERIOD_LAST) begin
                        half_pos_in = 9'd0;
                        half_odd_in = !half_odd_ff;
                     end else begin
                        half_pos_in = half_pos_ff + 9'd1;
                     end
                  end
               end
            end
            ACT_ADJUST: begin
               if (sum < 18'sd0) begin
                  count_in = 16'd0;
               end else if (sum > $signed({2'b00, cfg.max_seconds})) begin
                  count_in = cfg.max_seconds;
               end else begin
                  count_in = sum[15:0];
               end
               if (count_in != 16'd0) begin
                  next_dec_in   = clock_ff + {16'd0, cfg.start_delay_ms};
                  blink_diff_in = 32'd0 - {16'd0, cfg.blink_delay_ms};
                  half_pos_in   = 9'd0;
                  half_odd_in   = 1'b0;
               end
            end
            ACT_CLEAR: begin
               count_in = 16'd0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end

      result.seconds_left = count_in;
      result.expired      = (count_in == 16'd0);
      result.colon_on     = blink_diff_in[31] || !half_odd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff      <= 32'd0;
         next_dec_ff   <= 32'd0;
         blink_diff_ff <= 32'd0;
         half_pos_ff   <= 9'd0;
         half_odd_ff   <= 1'b0;
         count_ff      <= 16'd0;
      end else begin
         clock_ff      <= clock_in;
         next_dec_ff   <= next_dec_in;
         blink_diff_ff <= blink_diff_in;
         half_pos_ff   <= half_pos_in;
         half_odd_ff   <= half_odd_in;
         count_ff      <= count_in;
      end
   end

endmodule
